/* sv/irvoa_pkg.sv */
// shared types, constants and sensor weight tables for the ir vector obstacle avoidance block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package irvoa_pkg;

    localparam int NSENS    = 8;
    localparam int PROX_W   = 12;
    localparam int SPD_W    = 16;
    localparam int MAXS_W   = 15;
    localparam int ALPHA_W  = 17;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 28;
    localparam int PAIR_W   = 29;
    localparam int SUM_W    = 30;
    localparam int MAG_W    = 29;
    localparam int SQ_W     = 58;
    localparam int SQ_STEPS = 32;
    localparam int REM_W    = 34;
    localparam int ROOT_W   = 32;
    localparam int DIVR_W   = 30;
    localparam int QUO_W    = 17;
    localparam int BLD_W    = 18;
    localparam int BPROD_W  = 34;

    // floor(n / 11193) for any n below 2^30 as (n * RECIP) >> RECIP_SH
    localparam int RECIP_W  = 31;
    localparam int RPROD_W  = 61;
    localparam int RECIP_SH = 44;

    // accept edge to the edge that takes the result
    localparam int LATENCY  = 43;

    localparam logic [MAXS_W-1:0]  MAX_SPEED_RST = 15'd3277;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
    localparam logic [DIVR_W-1:0]  DIVISOR       = 30'd11193;
    localparam logic [RECIP_W-1:0] RECIP         = 31'd1571713218;
    // smallest root whose quotient exceeds 1.0
    localparam logic [ROOT_W-2:0]  SAT_LIMIT     = 31'd733555641;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COS_Q14 [NSENS] = '{
        16'sd4854, 16'sd11762, 16'sd16384, 16'sd7821,
        -16'sd7889, -16'sd16384, -16'sd11744, -16'sd4829
    };
    localparam t_coef SIN_Q14 [NSENS] = '{
        16'sd15648, 16'sd11406, 16'sd0, -16'sd14397,
        -16'sd14360, 16'sd26, 16'sd11431, 16'sd15656
    };

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_CW   = 2'd1,
        TURN_CCW  = 2'd2
    } t_turn;

    typedef struct packed {
        logic valid;
        logic active;
        logic cw;
        logic sat;
    } t_side;

endpackage

/* sv/irvoa_isqrt.sv */
// pipelined integer square root of 16*m2, one root bit per stage
// depends on irvoa_pkg
`timescale 1ns / 1ps

module irvoa_isqrt
    import irvoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SQ_W-1:0]   i_m2,
    input  t_side             i_side,
    output logic [ROOT_W-2:0] o_root,
    output t_side             o_side
);

    logic [REM_W-1:0]  r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];
    logic [SQ_W-1:0]   r_v    [SQ_STEPS];
    t_side             r_side [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic [REM_W-1:0]  w_rem_s;
            logic [ROOT_W-1:0] w_root_s;
            logic [SQ_W-1:0]   w_v_s;
            t_side             w_side_s;
            logic [63:0]       w_v64;
            logic [1:0]        w_pair;
            logic [REM_W+1:0]  w_cand;
            logic [REM_W+1:0]  w_trial;
            logic              w_take;
            logic [REM_W-1:0]  n_rem;

            if (k == 0) begin : g_first
                assign w_rem_s  = '0;
                assign w_root_s = '0;
                assign w_v_s    = i_m2;
                assign w_side_s = i_side;
            end else begin : g_next
                assign w_rem_s  = r_rem[k-1];
                assign w_root_s = r_root[k-1];
                assign w_v_s    = r_v[k-1];
                assign w_side_s = r_side[k-1];
            end

            // radicand is m2 shifted left by four
            assign w_v64   = {2'b00, w_v_s, 4'b0000};
            assign w_pair  = w_v64[2*(SQ_STEPS-1-k)+1 -: 2];
            assign w_cand  = {w_rem_s, w_pair};
            assign w_trial = {w_root_s, 2'b01};
            assign w_take  = (w_cand >= w_trial);
            assign n_rem   = w_take ? REM_W'(w_cand - w_trial) : w_cand[REM_W-1:0];

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= {w_root_s[ROOT_W-2:0], w_take};
                r_v[k]    <= w_v_s;
                if (!i_rst_n) begin
                    r_side[k] <= '0;
                end else begin
                    r_side[k] <= w_side_s;
                end
            end
        end
    endgenerate

    assign o_root = r_root[SQ_STEPS-1][ROOT_W-2:0];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

/* sv/irvoa_div.sv */
// divide by the fixed vector scale as a single registered reciprocal multiply
// depends on irvoa_pkg
`timescale 1ns / 1ps

module irvoa_div
    import irvoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIVR_W-1:0] i_dvd,
    input  t_side             i_side,
    output logic [QUO_W-1:0]  o_quo,
    output t_side             o_side
);

    logic [RPROD_W-1:0] r_prod;
    t_side              r_side;

    always_ff @(posedge i_clk) begin
        r_prod <= RPROD_W'(i_dvd) * RPROD_W'(RECIP);
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    // quotient is exact for every dividend below 2^30
    assign o_quo  = r_prod[RECIP_SH +: QUO_W];
    assign o_side = r_side;

endmodule

/* sv/ir_vector_obstacle_avoidance.sv */
// top level: proximity vector sum, magnitude, avoidance weight and wheel speed blend
// uses irvoa_pkg, irvoa_isqrt and irvoa_div
// throughput: one transaction per cycle, set by a fully pipelined datapath; busy only in reset
// reset: synchronous active low, clears the pipeline valid bits and sets max_speed to 3277
`timescale 1ns / 1ps

module ir_vector_obstacle_avoidance
    import irvoa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [MAXS_W-1:0]        i_cfg_wdata,
    input  logic [PROX_W-1:0]        i_prox_0,
    input  logic [PROX_W-1:0]        i_prox_1,
    input  logic [PROX_W-1:0]        i_prox_2,
    input  logic [PROX_W-1:0]        i_prox_3,
    input  logic [PROX_W-1:0]        i_prox_4,
    input  logic [PROX_W-1:0]        i_prox_5,
    input  logic [PROX_W-1:0]        i_prox_6,
    input  logic [PROX_W-1:0]        i_prox_7,
    input  logic signed [SPD_W-1:0]  i_left_speed_now,
    input  logic signed [SPD_W-1:0]  i_right_speed_now,
    output logic                     o_done,
    output logic signed [SPD_W-1:0]  o_left_speed,
    output logic signed [SPD_W-1:0]  o_right_speed,
    output logic [ALPHA_W-1:0]       o_avoid_weight,
    output logic [1:0]               o_turn_dir
);

    logic [MAXS_W-1:0] r_max_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
        end else if (i_cfg_we) begin
            r_max_speed <= i_cfg_wdata;
        end
    end

    assign busy = ~i_rst_n;

    logic              w_accept;
    logic [PROX_W-1:0] w_prox [NSENS];
    logic signed [SPD_W:0] w_spd_sum;

    assign w_accept  = start & ~busy;
    assign w_prox[0] = i_prox_0;
    assign w_prox[1] = i_prox_1;
    assign w_prox[2] = i_prox_2;
    assign w_prox[3] = i_prox_3;
    assign w_prox[4] = i_prox_4;
    assign w_prox[5] = i_prox_5;
    assign w_prox[6] = i_prox_6;
    assign w_prox[7] = i_prox_7;
    assign w_spd_sum = {i_left_speed_now[SPD_W-1], i_left_speed_now}
                     + {i_right_speed_now[SPD_W-1], i_right_speed_now};

    // stage 1: constant weight products
    logic signed [PROD_W-1:0] r_px [NSENS];
    logic signed [PROD_W-1:0] r_py [NSENS];
    logic                     r_vld1, r_back1;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSENS; i++) begin
            r_px[i] <= PROD_W'($signed({1'b0, w_prox[i]}) * COS_Q14[i]);
            r_py[i] <= PROD_W'($signed({1'b0, w_prox[i]}) * SIN_Q14[i]);
        end
        r_back1 <= w_spd_sum[SPD_W];
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= w_accept;
        end
    end

    // stage 2: pairwise sums
    logic signed [PAIR_W-1:0] r_x2 [NSENS/2];
    logic signed [PAIR_W-1:0] r_y2 [NSENS/2];
    logic                     r_vld2, r_back2;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NSENS/2; j++) begin
            r_x2[j] <= PAIR_W'(r_px[2*j]) + PAIR_W'(r_px[2*j+1]);
            r_y2[j] <= PAIR_W'(r_py[2*j]) + PAIR_W'(r_py[2*j+1]);
        end
        r_back2 <= r_back1;
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    // stage 3: vector components in q14
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic                    r_vld3, r_back3;

    always_ff @(posedge i_clk) begin
        r_sx    <= (SUM_W'(r_x2[0]) + SUM_W'(r_x2[1])) + (SUM_W'(r_x2[2]) + SUM_W'(r_x2[3]));
        r_sy    <= (SUM_W'(r_y2[0]) + SUM_W'(r_y2[1])) + (SUM_W'(r_y2[2]) + SUM_W'(r_y2[3]));
        r_back3 <= r_back2;
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
    end

    // stage 4: magnitudes and decision flags
    logic [MAG_W-1:0] r_ax, r_ay;
    t_side            r_side4;
    t_side            n_side4;
    logic             w_sx_neg, w_sx_pos, w_sy_neg, w_sy_pos;

    assign w_sx_neg = r_sx[SUM_W-1];
    assign w_sy_neg = r_sy[SUM_W-1];
    assign w_sx_pos = ~w_sx_neg & (r_sx != '0);
    assign w_sy_pos = ~w_sy_neg & (r_sy != '0);

    always_comb begin
        n_side4.valid  = r_vld3;
        // only a vector in the half plane of travel steers
        n_side4.active = r_back3 ? w_sy_neg : w_sy_pos;
        n_side4.cw     = r_back3 ? w_sx_pos : w_sx_neg;
        n_side4.sat    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_ax <= MAG_W'(w_sx_neg ? -r_sx : r_sx);
        r_ay <= MAG_W'(w_sy_neg ? -r_sy : r_sy);
        if (!i_rst_n) begin
            r_side4 <= '0;
        end else begin
            r_side4 <= n_side4;
        end
    end

    // stage 5: squares
    logic [SQ_W-1:0] r_sqx, r_sqy;
    t_side           r_side5;

    always_ff @(posedge i_clk) begin
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
        if (!i_rst_n) begin
            r_side5 <= '0;
        end else begin
            r_side5 <= r_side4;
        end
    end

    // stage 6: squared length
    logic [SQ_W-1:0] r_m2;
    t_side           r_side6;

    always_ff @(posedge i_clk) begin
        r_m2 <= r_sqx + r_sqy;
        if (!i_rst_n) begin
            r_side6 <= '0;
        end else begin
            r_side6 <= r_side5;
        end
    end

    logic [ROOT_W-2:0] w_root;
    t_side             w_side_sq;

    irvoa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_m2    (r_m2),
        .i_side  (r_side6),
        .o_root  (w_root),
        .o_side  (w_side_sq)
    );

    // clamp: a root at or past the limit saturates alpha, divider sees zero
    logic [DIVR_W-1:0] r_dvd;
    t_side             r_side_c;
    t_side             n_side_c;
    logic              w_sat;

    assign w_sat = (w_root >= SAT_LIMIT);

    always_comb begin
        n_side_c     = w_side_sq;
        n_side_c.sat = w_sat;
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= w_sat ? '0 : w_root[DIVR_W-1:0];
        if (!i_rst_n) begin
            r_side_c <= '0;
        end else begin
            r_side_c <= n_side_c;
        end
    end

    logic [QUO_W-1:0] w_quo;
    t_side            w_side_dv;

    irvoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dvd   (r_dvd),
        .i_side  (r_side_c),
        .o_quo   (w_quo),
        .o_side  (w_side_dv)
    );

    // alpha and blend factor 65536 - 2*alpha
    logic [ALPHA_W-1:0]       r_alpha_a;
    logic signed [BLD_W-1:0]  r_coef;
    t_side                    r_side_a;
    logic [ALPHA_W-1:0]       n_alpha;

    always_comb begin
        if (!w_side_dv.active) begin
            n_alpha = '0;
        end else if (w_side_dv.sat) begin
            n_alpha = ALPHA_ONE;
        end else begin
            n_alpha = w_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha_a <= n_alpha;
        r_coef    <= BLD_W'(19'sd65536 - $signed({1'b0, n_alpha, 1'b0}));
        if (!i_rst_n) begin
            r_side_a <= '0;
        end else begin
            r_side_a <= w_side_dv;
        end
    end

    // speed product
    logic signed [BPROD_W-1:0] r_bprod;
    logic [ALPHA_W-1:0]        r_alpha_p;
    t_side                     r_side_p;

    always_ff @(posedge i_clk) begin
        r_bprod   <= $signed({1'b0, r_max_speed}) * r_coef;
        r_alpha_p <= r_alpha_a;
        if (!i_rst_n) begin
            r_side_p <= '0;
        end else begin
            r_side_p <= r_side_a;
        end
    end

    // output: round to nearest, ties up
    logic signed [BPROD_W-1:0] w_rnd;
    logic signed [SPD_W-1:0]   w_blend;
    logic signed [SPD_W-1:0]   w_max_s;
    logic                      w_cw_turn, w_ccw_turn;
    t_turn                     n_turn;

    assign w_rnd      = r_bprod + 34'sd32768;
    assign w_blend    = w_rnd[SPD_W+15:16];
    assign w_max_s    = $signed({1'b0, r_max_speed});
    assign w_cw_turn  = r_side_p.active & r_side_p.cw;
    assign w_ccw_turn = r_side_p.active & ~r_side_p.cw;

    always_comb begin
        if (w_cw_turn) begin
            n_turn = TURN_CW;
        end else if (w_ccw_turn) begin
            n_turn = TURN_CCW;
        end else begin
            n_turn = TURN_NONE;
        end
    end

    logic signed [SPD_W-1:0] r_ls, r_rs;
    logic [ALPHA_W-1:0]      r_aw;
    t_turn                   r_turn;
    logic                    r_done;

    always_ff @(posedge i_clk) begin
        r_ls   <= w_ccw_turn ? w_blend : w_max_s;
        r_rs   <= w_cw_turn ? w_blend : w_max_s;
        r_aw   <= r_alpha_p;
        r_turn <= n_turn;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_side_p.valid;
        end
    end

    assign o_done         = r_done;
    assign o_left_speed   = r_ls;
    assign o_right_speed  = r_rs;
    assign o_avoid_weight = r_aw;
    assign o_turn_dir     = r_turn;

endmodule

/* sv/irvoa_chk.sv */
// port-level checker for ir_vector_obstacle_avoidance and its bind statement
// depends on irvoa_pkg and the top level
`timescale 1ns / 1ps

module irvoa_chk
    import irvoa_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_done,
    input logic signed [SPD_W-1:0] o_left_speed,
    input logic signed [SPD_W-1:0] o_right_speed,
    input logic [ALPHA_W-1:0]      o_avoid_weight,
    input logic [1:0]              o_turn_dir
);

    // every result strobe traces back to a transaction a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    a_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_turn_dir == TURN_NONE) |->
            (o_avoid_weight == '0 && o_left_speed == o_right_speed))
        else $error("no turn but weight or speeds differ");

    a_cw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_turn_dir == TURN_CW) |-> (o_left_speed >= o_right_speed))
        else $error("clockwise turn slows the wrong wheel");

    a_ccw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_turn_dir == TURN_CCW) |-> (o_right_speed >= o_left_speed))
        else $error("counterclockwise turn slows the wrong wheel");

    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_avoid_weight <= ALPHA_ONE))
        else $error("avoidance weight above 1.0");

endmodule

bind ir_vector_obstacle_avoidance irvoa_chk u_chk (.*);

/* dv/ir_vector_obstacle_avoidance_test.sv */
// self-checking testbench for ir_vector_obstacle_avoidance: directed and random sensor frames,
// max_speed sweeps and sender idle phases, checked against an in-bench wheel command predictor
// depends on irvoa_pkg and the ir_vector_obstacle_avoidance rtl
`timescale 1ns / 1ps

module ir_vector_obstacle_avoidance_test;

    import irvoa_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_GAP        = 40;
    localparam int PHASE_ITEMS    = 225;

    typedef struct packed {
        logic [NSENS-1:0][PROX_W-1:0] prox;
        logic signed [SPD_W-1:0]      left_now;
        logic signed [SPD_W-1:0]      right_now;
    } t_frame;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_speed;
        logic signed [SPD_W-1:0] right_speed;
        logic [ALPHA_W-1:0]      avoid_weight;
        t_turn                   turn_dir;
    } t_wheel_cmd;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [MAXS_W-1:0]       i_cfg_wdata = '0;
    logic [PROX_W-1:0]       i_prox_0 = '0;
    logic [PROX_W-1:0]       i_prox_1 = '0;
    logic [PROX_W-1:0]       i_prox_2 = '0;
    logic [PROX_W-1:0]       i_prox_3 = '0;
    logic [PROX_W-1:0]       i_prox_4 = '0;
    logic [PROX_W-1:0]       i_prox_5 = '0;
    logic [PROX_W-1:0]       i_prox_6 = '0;
    logic [PROX_W-1:0]       i_prox_7 = '0;
    logic signed [SPD_W-1:0] i_left_speed_now = '0;
    logic signed [SPD_W-1:0] i_right_speed_now = '0;
    logic                    o_done;
    logic signed [SPD_W-1:0] o_left_speed;
    logic signed [SPD_W-1:0] o_right_speed;
    logic [ALPHA_W-1:0]      o_avoid_weight;
    logic [1:0]              o_turn_dir;

    t_wheel_cmd        wheel_cmd_q[$];
    t_wheel_cmd        want_cmd;
    t_frame            seen_frame;
    logic [MAXS_W-1:0] max_speed_model;
    int                error_count = 0;
    int                quiet_cycles = 0;

    ir_vector_obstacle_avoidance u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_prox_0          (i_prox_0),
        .i_prox_1          (i_prox_1),
        .i_prox_2          (i_prox_2),
        .i_prox_3          (i_prox_3),
        .i_prox_4          (i_prox_4),
        .i_prox_5          (i_prox_5),
        .i_prox_6          (i_prox_6),
        .i_prox_7          (i_prox_7),
        .i_left_speed_now  (i_left_speed_now),
        .i_right_speed_now (i_right_speed_now),
        .o_done            (o_done),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_avoid_weight    (o_avoid_weight),
        .o_turn_dir        (o_turn_dir)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic t_wheel_cmd predict_wheel_cmd(t_frame f, logic [MAXS_W-1:0] top_speed);
        longint          sx;
        longint          sy;
        longint          reading;
        longint          prod;
        longint          blended;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned alpha;
        int              speed_sum;
        logic            backward;
        logic            active;
        logic            cw;
        t_wheel_cmd      cmd;
        sx = 0;
        sy = 0;
        for (int i = 0; i < NSENS; i++) begin
            reading = longint'(f.prox[i]);
            sx += reading * longint'(COS_Q14[i]);
            sy += reading * longint'(SIN_Q14[i]);
        end
        speed_sum = int'(f.left_now) + int'(f.right_now);
        backward  = speed_sum < 0;
        // only a vector in the half plane of travel causes a turn
        active    = backward ? (sy < 0) : (sy > 0);
        cmd.left_speed   = $signed({1'b0, top_speed});
        cmd.right_speed  = $signed({1'b0, top_speed});
        cmd.avoid_weight = '0;
        cmd.turn_dir     = TURN_NONE;
        if (active) begin
            ax    = (sx < 0) ? -sx : sx;
            ay    = (sy < 0) ? -sy : sy;
            alpha = int_sqrt(16 * (ax * ax + ay * ay)) / DIVISOR;
            if (alpha > ALPHA_ONE) alpha = ALPHA_ONE;
            cw      = backward ? (sx > 0) : (sx < 0);
            // round to nearest, ties up; the offset keeps the sum positive for the shift
            prod    = longint'(top_speed) * (65536 - 2 * longint'(alpha));
            blended = ((prod + 32768 + (longint'(1) << 32)) >>> 16) - 65536;
            cmd.avoid_weight = alpha[ALPHA_W-1:0];
            if (cw) begin
                cmd.turn_dir    = TURN_CW;
                cmd.right_speed = blended[SPD_W-1:0];
            end else begin
                cmd.turn_dir   = TURN_CCW;
                cmd.left_speed = blended[SPD_W-1:0];
            end
        end
        return cmd;
    endfunction

    // prediction at the accepting edge, result check at the strobe edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_speed_model = MAX_SPEED_RST;
        end else begin
            if (o_done) begin
                if (wheel_cmd_q.size() == 0) begin
                    $error("result with no transaction outstanding");
                    error_count++;
                end else begin
                    want_cmd = wheel_cmd_q.pop_front();
                    if (o_left_speed !== want_cmd.left_speed) begin
                        $error("left_speed: expected %0d, actual %0d",
                               want_cmd.left_speed, o_left_speed);
                        error_count++;
                    end
                    if (o_right_speed !== want_cmd.right_speed) begin
                        $error("right_speed: expected %0d, actual %0d",
                               want_cmd.right_speed, o_right_speed);
                        error_count++;
                    end
                    if (o_avoid_weight !== want_cmd.avoid_weight) begin
                        $error("avoid_weight: expected %0d, actual %0d",
                               want_cmd.avoid_weight, o_avoid_weight);
                        error_count++;
                    end
                    if (o_turn_dir !== 2'(want_cmd.turn_dir)) begin
                        $error("turn_dir: expected %0d, actual %0d",
                               want_cmd.turn_dir, o_turn_dir);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) max_speed_model = i_cfg_wdata;
            if (start && !busy) begin
                seen_frame.prox      = {i_prox_7, i_prox_6, i_prox_5, i_prox_4,
                                        i_prox_3, i_prox_2, i_prox_1, i_prox_0};
                seen_frame.left_now  = i_left_speed_now;
                seen_frame.right_now = i_right_speed_now;
                wheel_cmd_q.push_back(predict_wheel_cmd(seen_frame, max_speed_model));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_frame hot_frame(logic [NSENS-1:0] mask, logic [PROX_W-1:0] level,
                                         logic signed [SPD_W-1:0] l_now,
                                         logic signed [SPD_W-1:0] r_now);
        t_frame f;
        for (int i = 0; i < NSENS; i++) f.prox[i] = mask[i] ? level : '0;
        f.left_now  = l_now;
        f.right_now = r_now;
        return f;
    endfunction

    function automatic logic signed [SPD_W-1:0] random_speed(int kind);
        case (kind)
            1:       return {1'b0, 15'($urandom)};
            2:       return {1'b1, 15'($urandom)};
            3:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_frame random_frame();
        t_frame           f;
        int               mode;
        int               kind;
        logic [NSENS-1:0] hot;
        mode = $urandom_range(0, 5);
        case (mode)
            1:       hot = 8'hC3;
            2:       hot = 8'h38;
            3:       hot = 8'(1 << $urandom_range(0, NSENS - 1));
            default: hot = 8'($urandom);
        endcase
        for (int i = 0; i < NSENS; i++) begin
            case (mode)
                0: f.prox[i] = 12'($urandom);
                3: f.prox[i] = hot[i] ? ($urandom_range(0, 1) ? 12'hFFF : 12'($urandom)) : '0;
                4: f.prox[i] = 12'($urandom_range(0, 63));
                5: begin
                    case ($urandom_range(0, 2))
                        0:       f.prox[i] = '0;
                        1:       f.prox[i] = 12'hFFF;
                        default: f.prox[i] = 12'($urandom);
                    endcase
                end
                default: f.prox[i] = hot[i] ? 12'($urandom_range(2048, 4095))
                                            : 12'($urandom_range(0, 255));
            endcase
        end
        // front obstacles mostly while driving forward, rear ones mostly while reversing
        if (mode == 1 && $urandom_range(0, 3) != 0)
            kind = 1;
        else if (mode == 2 && $urandom_range(0, 3) != 0)
            kind = 2;
        else
            kind = $urandom_range(0, 3);
        f.left_now  = random_speed(kind);
        f.right_now = random_speed(kind);
        return f;
    endfunction

    task automatic send_frame(input t_frame f, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_prox_0          <= f.prox[0];
        i_prox_1          <= f.prox[1];
        i_prox_2          <= f.prox[2];
        i_prox_3          <= f.prox[3];
        i_prox_4          <= f.prox[4];
        i_prox_5          <= f.prox[5];
        i_prox_6          <= f.prox[6];
        i_prox_7          <= f.prox[7];
        i_left_speed_now  <= f.left_now;
        i_right_speed_now <= f.right_now;
        start             <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        do @(posedge i_clk); while (wheel_cmd_q.size() != 0);
    endtask

    task automatic write_max_speed(input logic [MAXS_W-1:0] value);
        drain_pipeline();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_directed_frames();
        t_frame f;
        send_frame(hot_frame(8'h00, 12'h000, 16'sd0, 16'sd0), 0);
        send_frame(hot_frame(8'hFF, 12'hFFF, 16'sd32767, 16'sd32767), 0);
        send_frame(hot_frame(8'hFF, 12'hFFF, -16'sd32768, -16'sd32768), 0);
        send_frame(hot_frame(8'hFF, 12'hAAA, 16'sh5555, -16'sh2AAB), 0);
        send_frame(hot_frame(8'hFF, 12'h555, -16'sh5556, 16'sh2AAA), 0);
        // front clusters: weight below 1.0, then saturated
        send_frame(hot_frame(8'h83, 12'hFFF, 16'sd256, 16'sd256), 0);
        send_frame(hot_frame(8'hC3, 12'hFFF, 16'sd256, 16'sd256), 0);
        send_frame(hot_frame(8'hC0, 12'hFFF, 16'sd100, 16'sd0), 0);
        send_frame(hot_frame(8'h40, 12'd100, 16'sd1, 16'sd1), 0);
        send_frame(hot_frame(8'h01, 12'd1, 16'sd0, 16'sd0), 0);
        send_frame(hot_frame(8'h20, 12'hFFF, 16'sd10, 16'sd10), 0);
        // zero x component, forward
        send_frame(hot_frame(8'h24, 12'd2000, 16'sd0, 16'sd0), 0);
        // zero x component, reversing
        f = hot_frame(8'h00, 12'h000, -16'sd256, -16'sd256);
        f.prox[2] = 12'd16;
        f.prox[3] = 12'd3391;
        f.prox[4] = 12'd3395;
        send_frame(f, 0);
        // rear obstacles while reversing
        send_frame(hot_frame(8'h08, 12'hFFF, -16'sd256, -16'sd256), 0);
        send_frame(hot_frame(8'h10, 12'hFFF, -16'sd256, -16'sd256), 0);
        // speed sum of -1 reverses, 0 goes forward
        send_frame(hot_frame(8'h18, 12'hFFF, -16'sd32768, 16'sd32767), 0);
        send_frame(hot_frame(8'h83, 12'd2000, -16'sd32767, 16'sd32767), 0);
        send_frame(hot_frame(8'h18, 12'hFFF, 16'sd32767, -16'sd32767), 0);
    endtask

    task automatic test_speed_extremes();
        logic [MAXS_W-1:0] limits [3] = '{15'd32767, 15'd0, 15'd1};
        foreach (limits[k]) begin
            write_max_speed(limits[k]);
            send_frame(hot_frame(8'hC3, 12'hFFF, 16'sd256, 16'sd256), 0);
            send_frame(hot_frame(8'h08, 12'hFFF, -16'sd256, -16'sd256), 0);
            repeat (14) send_frame(random_frame(), 0);
        end
    endtask

    task automatic test_random_traffic();
        int idle_pcts [4] = '{0, 73, 34, 0};
        foreach (idle_pcts[ph]) begin
            write_max_speed(15'($urandom));
            repeat (PHASE_ITEMS) send_frame(random_frame(), idle_pcts[ph]);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_speed_extremes();
        test_random_traffic();
        drain_pipeline();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
